// ===== rtl/assert_macros.svh =====
// assertion macros shared by the gesture classifier modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define AGC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never be seen outside reset
`define AGC_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define AGC_ASSERT(label, clk, rst_n, prop)
`define AGC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/agc_pkg.sv =====
// types and constants of the accelerometer gesture classifier
`default_nettype none
package agc_pkg;

    // configuration port
    localparam int CFG_W     = 28;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_G     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_TOL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREEFALL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TH_3G       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TH_6G       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TH_8G       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_TOL    = 3'd7;

    // register reset values
    localparam logic [3:0]  RST_RANGE_G     = 4'd2;
    localparam logic [13:0] RST_SHAKE_TOL   = 14'd400;
    localparam logic [2:0]  RST_SHAKE_LIMIT = 3'd4;
    localparam logic [27:0] RST_FREEFALL    = 28'd160000;
    localparam logic [27:0] RST_TH_3G       = 28'd9437184;
    localparam logic [27:0] RST_TH_6G       = 28'd37748736;
    localparam logic [27:0] RST_TH_8G       = 28'd67108864;
    localparam logic [9:0]  RST_TILT_TOL    = 10'd200;

    // low byte contribution to the scaled axis, built in or not
    localparam logic USE_LOW_BITS = 1'b0;

    // datapath widths
    localparam int MG_W    = 15;
    localparam int SQ_W    = 27;
    localparam int FORCE_W = 28;
    localparam int CODE_W  = 4;

    // posture and gesture codes
    localparam logic [CODE_W-1:0] G_NONE      = 4'd0;
    localparam logic [CODE_W-1:0] G_UP        = 4'd1;
    localparam logic [CODE_W-1:0] G_DOWN      = 4'd2;
    localparam logic [CODE_W-1:0] G_LEFT      = 4'd3;
    localparam logic [CODE_W-1:0] G_RIGHT     = 4'd4;
    localparam logic [CODE_W-1:0] G_FACE_UP   = 4'd5;
    localparam logic [CODE_W-1:0] G_FACE_DOWN = 4'd6;
    localparam logic [CODE_W-1:0] G_FREEFALL  = 4'd7;
    localparam logic [CODE_W-1:0] G_3G        = 4'd8;
    localparam logic [CODE_W-1:0] G_6G        = 4'd9;
    localparam logic [CODE_W-1:0] G_8G        = 4'd10;
    localparam logic [CODE_W-1:0] G_SHAKE     = 4'd11;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef struct packed {
        logic [3:0]  range_g;
        logic [13:0] shake_tol;
        logic [2:0]  shake_limit;
        logic [27:0] freefall;
        logic [27:0] th_3g;
        logic [27:0] th_6g;
        logic [27:0] th_8g;
        logic [9:0]  tilt_tol;
    } cfg_t;

    // one scaled sample with the squares of its axes
    typedef struct packed {
        logic signed [MG_W-1:0] x_mg;
        logic signed [MG_W-1:0] y_mg;
        logic signed [MG_W-1:0] z_mg;
        logic [SQ_W-1:0]        sq_x;
        logic [SQ_W-1:0]        sq_y;
        logic [SQ_W-1:0]        sq_z;
    } sample_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } qstat_t;

endpackage
`default_nettype wire

// ===== rtl/agc_front.sv =====
// front part: scales the raw axes to milli-g and squares them
`default_nettype none
module agc_front (
    input  wire logic signed [7:0] x_high,
    input  wire logic signed [7:0] x_low,
    input  wire logic signed [7:0] y_high,
    input  wire logic signed [7:0] y_low,
    input  wire logic signed [7:0] z_high,
    input  wire logic signed [7:0] z_low,
    input  agc_pkg::cfg_t          cfg,
    output agc_pkg::sample_t       sample
);

    // high byte x8, plus low byte/64 toward zero if enabled, times range
    function automatic logic signed [agc_pkg::MG_W-1:0] scale_axis(
        input logic signed [7:0] hi,
        input logic signed [7:0] lo,
        input logic [1:0]        sh
    );
        logic signed [11:0]              base;
        logic signed [11:0]              lo_q;
        logic signed [11:0]              v;
        logic signed [agc_pkg::MG_W-1:0] ext;
        base = $signed({hi[7], hi, 3'b000});
        lo_q = $signed({{10{lo[7]}}, lo[7:6]})
             + ((lo[7] && (lo[5:0] != 6'd0)) ? 12'sd1 : 12'sd0);
        v    = agc_pkg::USE_LOW_BITS ? (base + lo_q) : base;
        ext  = {{3{v[11]}}, v};
        unique case (sh)
            2'd1:    scale_axis = ext <<< 1;
            2'd2:    scale_axis = ext <<< 2;
            default: scale_axis = ext <<< 3;
        endcase
    endfunction

    logic [1:0]                      range_sh;
    logic signed [agc_pkg::MG_W-1:0] rx;
    logic signed [agc_pkg::MG_W-1:0] ry;
    logic signed [agc_pkg::MG_W-1:0] rz;
    logic signed [2*agc_pkg::MG_W-1:0] px;
    logic signed [2*agc_pkg::MG_W-1:0] py;
    logic signed [2*agc_pkg::MG_W-1:0] pz;

    // unsupported ranges round up to the next supported one; above 8 uses 8
    always_comb
    begin
        priority if (cfg.range_g <= 4'd2)
        begin
            range_sh = 2'd1;
        end
        else if (cfg.range_g <= 4'd4)
        begin
            range_sh = 2'd2;
        end
        else
        begin
            range_sh = 2'd3;
        end
    end

    assign rx = scale_axis(x_high, x_low, range_sh);
    assign ry = scale_axis(y_high, y_low, range_sh);
    assign rz = scale_axis(z_high, z_low, range_sh);

    // per axis square, never negative and below 2^27
    assign px = rx * rx;
    assign py = ry * ry;
    assign pz = rz * rz;

    // x and y are reported negated, z as is
    always_comb
    begin
        sample.x_mg = -rx;
        sample.y_mg = -ry;
        sample.z_mg = rz;
        sample.sq_x = px[agc_pkg::SQ_W-1:0];
        sample.sq_y = py[agc_pkg::SQ_W-1:0];
        sample.sq_z = pz[agc_pkg::SQ_W-1:0];
    end

endmodule
`default_nettype wire

// ===== rtl/agc_queue.sv =====
// two entry queue between the front and the back part
`default_nettype none
`include "assert_macros.svh"
module agc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  agc_pkg::sample_t      push_data,
    input  wire logic             pop,
    output agc_pkg::sample_t      head,
    output agc_pkg::qstat_t       stat
);

    agc_pkg::sample_t                 entry_reg [agc_pkg::QUEUE_DEPTH];
    logic [agc_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [agc_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [agc_pkg::QUEUE_CNT_W-1:0]  count_reg;
    logic [agc_pkg::QUEUE_CNT_W-1:0]  count_next;
    logic                             do_push;
    logic                             do_pop;

    assign do_push = push && !stat.full;
    assign do_pop  = pop && stat.not_empty;

    // status straight from the fill count
    always_comb
    begin
        stat.full      = (count_reg == agc_pkg::QUEUE_CNT_W'(agc_pkg::QUEUE_DEPTH));
        stat.not_empty = (count_reg != '0);
    end

    always_comb
    begin
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head = entry_reg[rd_ptr_reg];

    // fill count bookkeeping
    `AGC_ASSERT_NEVER(a_q_overfill, clk, rst_n,
        count_reg > agc_pkg::QUEUE_CNT_W'(agc_pkg::QUEUE_DEPTH))
    `AGC_ASSERT(a_q_push_grows, clk, rst_n,
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
    `AGC_ASSERT(a_q_pop_shrinks, clk, rst_n,
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))

endmodule
`default_nettype wire

// ===== rtl/agc_back.sv =====
// back part: force, shake detection, classification, debounce and result register
`default_nettype none
`include "assert_macros.svh"
module agc_back #(
    parameter int SHAKE_DAMPING   = 10,
    parameter int GESTURE_DAMPING = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  agc_pkg::cfg_t                          cfg,
    input  agc_pkg::sample_t                       head,
    input  wire logic                              head_valid,
    output logic                                   pop,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [agc_pkg::MG_W-1:0]        x_mg,
    output logic signed [agc_pkg::MG_W-1:0]        y_mg,
    output logic signed [agc_pkg::MG_W-1:0]        z_mg,
    output logic [agc_pkg::FORCE_W-1:0]            force_squared,
    output logic [agc_pkg::CODE_W-1:0]             posture,
    output logic [agc_pkg::CODE_W-1:0]             gesture,
    output logic                                   gesture_changed
);

    localparam int TW = $clog2(SHAKE_DAMPING + 1);
    localparam int SW = $clog2(GESTURE_DAMPING + 1);

    // shake and debounce state
    logic [2:0]                   shake_pol_reg;
    logic [2:0]                   shake_pol_next;
    logic [2:0]                   shake_count_reg;
    logic [2:0]                   shake_count_next;
    logic                         shaken_reg;
    logic                         shaken_next;
    logic [TW-1:0]                shake_timer_reg;
    logic [TW-1:0]                shake_timer_next;
    logic [agc_pkg::CODE_W-1:0]   cand_reg;
    logic [agc_pkg::CODE_W-1:0]   cand_next;
    logic [SW-1:0]                stab_reg;
    logic [SW-1:0]                stab_next;
    logic [agc_pkg::CODE_W-1:0]   stable_reg;
    logic [agc_pkg::CODE_W-1:0]   stable_next;
    logic                         changed;

    // result register
    logic                                 out_valid_reg;
    logic signed [agc_pkg::MG_W-1:0]      x_mg_reg;
    logic signed [agc_pkg::MG_W-1:0]      y_mg_reg;
    logic signed [agc_pkg::MG_W-1:0]      z_mg_reg;
    logic [agc_pkg::FORCE_W-1:0]          force_reg;
    logic [agc_pkg::CODE_W-1:0]           posture_reg;
    logic [agc_pkg::CODE_W-1:0]           gesture_reg;
    logic                                 changed_reg;

    logic [agc_pkg::FORCE_W-1:0]  force_sum;
    logic signed [15:0]           gx;
    logic signed [15:0]           gy;
    logic signed [15:0]           gz;
    logic signed [15:0]           tol_s;
    logic signed [15:0]           tilt_s;
    logic signed [15:0]           tilt_lo;
    logic signed [15:0]           tilt_hi;
    logic [2:0]                   swing;
    logic                         det;
    logic [TW-1:0]                timer_inc;
    logic [agc_pkg::CODE_W-1:0]   g;

    // take the next request whenever the result register is free or drains
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    assign force_sum = agc_pkg::FORCE_W'(head.sq_x) + agc_pkg::FORCE_W'(head.sq_y)
                     + agc_pkg::FORCE_W'(head.sq_z);

    assign gx      = 16'(head.x_mg);
    assign gy      = 16'(head.y_mg);
    assign gz      = 16'(head.z_mg);
    assign tol_s   = $signed({2'b00, cfg.shake_tol});
    assign tilt_s  = $signed({6'b000000, cfg.tilt_tol});
    assign tilt_lo = tilt_s - 16'sd1000;
    assign tilt_hi = 16'sd1000 - tilt_s;

    // polarity reversal per axis
    assign swing[0] = ((gx < -tol_s) && shake_pol_reg[0]) || ((gx > tol_s) && !shake_pol_reg[0]);
    assign swing[1] = ((gy < -tol_s) && shake_pol_reg[1]) || ((gy > tol_s) && !shake_pol_reg[1]);
    assign swing[2] = ((gz < -tol_s) && shake_pol_reg[2]) || ((gz > tol_s) && !shake_pol_reg[2]);
    assign det      = |swing;
    assign shake_pol_next = shake_pol_reg ^ swing;
    assign timer_inc = shake_timer_reg + 1'b1;

    // shake counter with damping decay
    always_comb
    begin
        shake_count_next = shake_count_reg;
        shaken_next      = shaken_reg;
        if (det && (shake_count_next < cfg.shake_limit))
        begin
            shake_count_next = shake_count_next + 3'd1;
            if (shake_count_next == cfg.shake_limit)
            begin
                shaken_next = 1'b1;
            end
        end
        if (timer_inc >= TW'(SHAKE_DAMPING))
        begin
            shake_timer_next = '0;
            if (shake_count_next != 3'd0)
            begin
                shake_count_next = shake_count_next - 3'd1;
                if (shake_count_next == 3'd0)
                begin
                    shaken_next = 1'b0;
                end
            end
        end
        else
        begin
            shake_timer_next = timer_inc;
        end
    end

    // classification, strongest condition first
    always_comb
    begin
        priority if (shaken_next)                g = agc_pkg::G_SHAKE;
        else if (force_sum < cfg.freefall)       g = agc_pkg::G_FREEFALL;
        else if (force_sum > cfg.th_8g)          g = agc_pkg::G_8G;
        else if (force_sum > cfg.th_6g)          g = agc_pkg::G_6G;
        else if (force_sum > cfg.th_3g)          g = agc_pkg::G_3G;
        else if (gx < tilt_lo)                   g = agc_pkg::G_LEFT;
        else if (gx > tilt_hi)                   g = agc_pkg::G_RIGHT;
        else if (gy < tilt_lo)                   g = agc_pkg::G_DOWN;
        else if (gy > tilt_hi)                   g = agc_pkg::G_UP;
        else if (gz < tilt_lo)                   g = agc_pkg::G_FACE_UP;
        else if (gz > tilt_hi)                   g = agc_pkg::G_FACE_DOWN;
        else                                     g = agc_pkg::G_NONE;
    end

    // debounce into a stable gesture
    always_comb
    begin
        if (g == cand_reg)
        begin
            cand_next = cand_reg;
            stab_next = (stab_reg < SW'(GESTURE_DAMPING)) ? stab_reg + 1'b1 : stab_reg;
        end
        else
        begin
            cand_next = g;
            stab_next = '0;
        end
        if ((cand_next != stable_reg) && (stab_next >= SW'(GESTURE_DAMPING)))
        begin
            stable_next = cand_next;
            changed     = 1'b1;
        end
        else
        begin
            stable_next = stable_reg;
            changed     = 1'b0;
        end
    end

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shake_pol_reg   <= '0;
            shake_count_reg <= '0;
            shaken_reg      <= 1'b0;
            shake_timer_reg <= '0;
            cand_reg        <= agc_pkg::G_NONE;
            stab_reg        <= '0;
            stable_reg      <= agc_pkg::G_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                shake_pol_reg   <= shake_pol_next;
                shake_count_reg <= shake_count_next;
                shaken_reg      <= shaken_next;
                shake_timer_reg <= shake_timer_next;
                cand_reg        <= cand_next;
                stab_reg        <= stab_next;
                stable_reg      <= stable_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_mg_reg    <= head.x_mg;
            y_mg_reg    <= head.y_mg;
            z_mg_reg    <= head.z_mg;
            force_reg   <= force_sum;
            posture_reg <= g;
            gesture_reg <= stable_next;
            changed_reg <= changed;
        end
    end

    assign out_valid       = out_valid_reg;
    assign x_mg            = x_mg_reg;
    assign y_mg            = y_mg_reg;
    assign z_mg            = z_mg_reg;
    assign force_squared   = force_reg;
    assign posture         = posture_reg;
    assign gesture         = gesture_reg;
    assign gesture_changed = changed_reg;

    // shake and debounce invariants
    `AGC_ASSERT_NEVER(a_shaken_needs_count, clk, rst_n,
        shaken_reg && (shake_count_reg == 3'd0))
    `AGC_ASSERT_NEVER(a_timer_in_range, clk, rst_n,
        shake_timer_reg >= TW'(SHAKE_DAMPING))
    `AGC_ASSERT_NEVER(a_stab_in_range, clk, rst_n,
        stab_reg > SW'(GESTURE_DAMPING))

endmodule
`default_nettype wire

// ===== rtl/accel_gesture_classifier.sv =====
// top level of the accelerometer gesture classifier
//
// Input channel: one raw three-axis sample per request (high and low byte per
// axis), taken at a clock edge with in_valid high and in_stall low.
// Output channel: one result per sample (scaled axes in milli-g, squared
// force, instantaneous posture, debounced gesture and a change flag), taken
// at an edge with out_valid high and out_stall low.
// Throughput: one sample per clock while out_stall is low. The front scales
// and squares the axes as the sample enters a two entry queue; the back pops
// one entry a cycle while the result register is free or drains, updates the
// shake and debounce state and loads the result register. A sample is held
// in the queue, and its result is offered from the edge after it is popped.
// When the receiver stalls, the result register holds and the queue fills;
// in_stall rises once both queue entries are occupied.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index at a clock
// edge; write only while no sample is in flight.
// Reset: registers take their default values, the shake and gesture state
// clears to none and both channels come up empty.
`default_nettype none
module accel_gesture_classifier #(
    parameter int SHAKE_DAMPING   = 10,
    parameter int GESTURE_DAMPING = 5
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [agc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [agc_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [7:0]                   x_high,
    input  wire logic signed [7:0]                   x_low,
    input  wire logic signed [7:0]                   y_high,
    input  wire logic signed [7:0]                   y_low,
    input  wire logic signed [7:0]                   z_high,
    input  wire logic signed [7:0]                   z_low,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [agc_pkg::MG_W-1:0]          x_mg,
    output logic signed [agc_pkg::MG_W-1:0]          y_mg,
    output logic signed [agc_pkg::MG_W-1:0]          z_mg,
    output logic [agc_pkg::FORCE_W-1:0]              force_squared,
    output logic [agc_pkg::CODE_W-1:0]               posture,
    output logic [agc_pkg::CODE_W-1:0]               gesture,
    output logic                                     gesture_changed
);

    agc_pkg::cfg_t    cfg_reg;
    agc_pkg::sample_t front_sample;
    agc_pkg::sample_t q_head;
    agc_pkg::qstat_t  q_stat;
    logic             q_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_g     <= agc_pkg::RST_RANGE_G;
            cfg_reg.shake_tol   <= agc_pkg::RST_SHAKE_TOL;
            cfg_reg.shake_limit <= agc_pkg::RST_SHAKE_LIMIT;
            cfg_reg.freefall    <= agc_pkg::RST_FREEFALL;
            cfg_reg.th_3g       <= agc_pkg::RST_TH_3G;
            cfg_reg.th_6g       <= agc_pkg::RST_TH_6G;
            cfg_reg.th_8g       <= agc_pkg::RST_TH_8G;
            cfg_reg.tilt_tol    <= agc_pkg::RST_TILT_TOL;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                agc_pkg::CFG_RANGE_G:     cfg_reg.range_g     <= cfg_data[3:0];
                agc_pkg::CFG_SHAKE_TOL:   cfg_reg.shake_tol   <= cfg_data[13:0];
                agc_pkg::CFG_SHAKE_LIMIT: cfg_reg.shake_limit <= cfg_data[2:0];
                agc_pkg::CFG_FREEFALL:    cfg_reg.freefall    <= cfg_data[27:0];
                agc_pkg::CFG_TH_3G:       cfg_reg.th_3g       <= cfg_data[27:0];
                agc_pkg::CFG_TH_6G:       cfg_reg.th_6g       <= cfg_data[27:0];
                agc_pkg::CFG_TH_8G:       cfg_reg.th_8g       <= cfg_data[27:0];
                agc_pkg::CFG_TILT_TOL:    cfg_reg.tilt_tol    <= cfg_data[9:0];
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign in_stall = q_stat.full;

    // scale and square
    agc_front u_front (
        .x_high (x_high),
        .x_low  (x_low),
        .y_high (y_high),
        .y_low  (y_low),
        .z_high (z_high),
        .z_low  (z_low),
        .cfg    (cfg_reg),
        .sample (front_sample)
    );

    // decoupling queue
    agc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (front_sample),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // classify and deliver
    agc_back #(
        .SHAKE_DAMPING   (SHAKE_DAMPING),
        .GESTURE_DAMPING (GESTURE_DAMPING)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .head            (q_head),
        .head_valid      (q_stat.not_empty),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .x_mg            (x_mg),
        .y_mg            (y_mg),
        .z_mg            (z_mg),
        .force_squared   (force_squared),
        .posture         (posture),
        .gesture         (gesture),
        .gesture_changed (gesture_changed)
    );

endmodule
`default_nettype wire
